// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// Each macro takes a label, the clock, the active-low reset and the property.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge out of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sat_pkg.sv -----
// ----------------------------------------------------------------------------
// sat_pkg
// Types and constants shared by the sorted table modules.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Default and largest supported table size.
  localparam int DEF_CAPACITY = 16;
  localparam int MAX_CAPACITY = 64;

  // Fixed field widths of the request and result channels.
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int FILL_W  = 7;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // One result as handed from the sequencer to the output register.
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic [FILL_W-1:0]  fill;
    logic               last;
  } result_t;

endpackage

// ----- design/sat_mem.sv -----
// ----------------------------------------------------------------------------
// sat_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_mem #(
  parameter int CAPACITY = sat_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(CAPACITY)-1:0] waddr_i,
  input  logic [sat_pkg::VALUE_W-1:0] wdata_i,
  input  logic [$clog2(CAPACITY)-1:0] raddr_i,
  output logic [sat_pkg::VALUE_W-1:0] rdata_o
);
  import sat_pkg::*;

  logic [VALUE_W-1:0] mem_q [CAPACITY];
  logic [VALUE_W-1:0] rdata_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read: the read data is registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sat_outq.sv -----
// ----------------------------------------------------------------------------
// sat_outq
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module sat_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sat_pkg::result_t            emit_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [sat_pkg::POS_W-1:0]   position_o,
  output logic [sat_pkg::VALUE_W-1:0] entry_value_o,
  output logic [sat_pkg::FILL_W-1:0]  fill_count_o,
  output logic                        last_o
);
  import sat_pkg::*;

  logic    valid_q;
  result_t res_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= emit_i.valid;
    end
  end

  // Payload is loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (free_o && emit_i.valid) begin
      res_q <= emit_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = res_q.status;
  assign position_o    = res_q.position;
  assign entry_value_o = res_q.value;
  assign fill_count_o  = res_q.fill;
  assign last_o        = res_q.last;

endmodule

// ----- design/sat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sat_ctrl
// Request sequencer: walks the entry store to insert, delete, search and dump.
// ----------------------------------------------------------------------------
module sat_ctrl #(
  parameter int CAPACITY = sat_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sat_pkg::REQ_W-1:0]   req_type_i,
  input  logic [sat_pkg::VALUE_W-1:0] key_value_i,
  input  logic                        out_free_i,
  output sat_pkg::result_t            emit_o,
  output logic                        mem_we_o,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr_o,
  output logic [sat_pkg::VALUE_W-1:0] mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr_o,
  input  logic [sat_pkg::VALUE_W-1:0] mem_rdata_i
);
  import sat_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_KEY,
    S_SCAN,
    S_SHIFT,
    S_DUMP,
    S_EMIT
  } state_e;

  state_e             state_q, state_d;
  req_e               req_q, req_d;
  logic [VALUE_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   addr_q;
  logic [IDX_W-1:0]   pos_q, pos_d;
  result_t            res_q, res_d;
  logic [IDX_W-1:0]   raddr;
  logic               is_tail;

  // The entry in the read register is the last stored one.
  assign is_tail = (CNT_W'(addr_q) + CNT_W'(1)) == cnt_q;

  // Next-state and store access logic.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    res_d       = res_q;
    raddr       = addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = mem_rdata_i;
    emit_o      = '0;
    in_ready_o  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d          = req_e'(req_type_i);
          key_d          = key_value_i;
          res_d.valid    = 1'b1;
          res_d.last     = 1'b1;
          res_d.position = '0;
          res_d.value    = key_value_i;
          res_d.fill     = FILL_W'(cnt_q);
          if (req_e'(req_type_i) == REQ_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              res_d.status = ST_FULL;
              state_d      = S_EMIT;
            end else if (cnt_q == '0) begin
              // Empty table: the key goes straight to the first slot.
              mem_we_o     = 1'b1;
              mem_waddr_o  = '0;
              mem_wdata_o  = key_value_i;
              cnt_d        = CNT_W'(1);
              res_d.status = ST_OK;
              res_d.fill   = FILL_W'(1);
              state_d      = S_EMIT;
            end else begin
              pos_d   = IDX_W'(cnt_q);
              raddr   = IDX_W'(cnt_q - CNT_W'(1));
              state_d = S_INS_WALK;
            end
          end else if (cnt_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d      = S_EMIT;
          end else begin
            raddr   = '0;
            state_d = (req_e'(req_type_i) == REQ_DUMP) ? S_DUMP : S_SCAN;
          end
        end
      end

      // Move larger and equal entries up one slot until the key's place is found.
      S_INS_WALK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        if ($signed(mem_rdata_i) >= $signed(key_q)) begin
          mem_wdata_o = mem_rdata_i;
          pos_d       = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = S_INS_KEY;
          end else begin
            raddr = pos_q - IDX_W'(2);
          end
        end else begin
          mem_wdata_o    = key_q;
          cnt_d          = cnt_q + CNT_W'(1);
          res_d.status   = ST_OK;
          res_d.position = POS_W'(pos_q);
          res_d.fill     = FILL_W'(cnt_q + CNT_W'(1));
          state_d        = S_EMIT;
        end
      end

      S_INS_KEY: begin
        mem_we_o       = 1'b1;
        mem_waddr_o    = '0;
        mem_wdata_o    = key_q;
        cnt_d          = cnt_q + CNT_W'(1);
        res_d.status   = ST_OK;
        res_d.position = '0;
        res_d.fill     = FILL_W'(cnt_q + CNT_W'(1));
        state_d        = S_EMIT;
      end

      // Look for the lowest entry equal to the key.
      S_SCAN: begin
        if (mem_rdata_i == key_q) begin
          res_d.status   = ST_OK;
          res_d.position = POS_W'(addr_q);
          if (req_q == REQ_SEARCH) begin
            res_d.value = mem_rdata_i;
            state_d     = S_EMIT;
          end else if (is_tail) begin
            cnt_d      = cnt_q - CNT_W'(1);
            res_d.fill = FILL_W'(cnt_q - CNT_W'(1));
            state_d    = S_EMIT;
          end else begin
            pos_d   = addr_q;
            raddr   = addr_q + IDX_W'(1);
            state_d = S_SHIFT;
          end
        end else if (is_tail) begin
          res_d.status = ST_MISSING;
          state_d      = S_EMIT;
        end else begin
          raddr = addr_q + IDX_W'(1);
        end
      end

      // Close the gap left by a deleted entry.
      S_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q - IDX_W'(1);
        mem_wdata_o = mem_rdata_i;
        if (is_tail) begin
          cnt_d      = cnt_q - CNT_W'(1);
          res_d.fill = FILL_W'(cnt_q - CNT_W'(1));
          state_d    = S_EMIT;
        end else begin
          raddr = addr_q + IDX_W'(1);
        end
      end

      // One result per entry; the read address holds while the output stalls.
      S_DUMP: begin
        if (out_free_i) begin
          emit_o.valid    = 1'b1;
          emit_o.status   = ST_OK;
          emit_o.position = POS_W'(addr_q);
          emit_o.value    = mem_rdata_i;
          emit_o.fill     = FILL_W'(cnt_q);
          emit_o.last     = is_tail;
          if (is_tail) begin
            state_d = S_IDLE;
          end else begin
            raddr = addr_q + IDX_W'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free_i) begin
          emit_o  = res_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    mem_raddr_o = raddr;
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      req_q   <= REQ_INSERT;
      key_q   <= '0;
      addr_q  <= '0;
      pos_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      req_q   <= req_d;
      key_q   <= key_d;
      addr_q  <= raddr;
      pos_q   <= pos_d;
      res_q   <= res_d;
    end
  end

endmodule

// ----- design/sorted_array_table_core.sv -----
// Sorted table of signed values with insert, delete, search and dump requests.
// A full or empty table is answered without a walk; insert walks down from the tail,
// search and delete walk up from slot zero, and dump gives one result per entry.
// One request at a time: the next is taken the cycle after its final result is loaded.
// The walk is set by the single read port of the entry store, one entry a cycle; a dump holds while the output stalls.
// Reset clears the entry count and control state; the store needs no clearing pass.
// ----------------------------------------------------------------------------
// sorted_array_table_core
// Top level: request sequencer, entry store and result register.
// ----------------------------------------------------------------------------
module sorted_array_table_core #(
  parameter int CAPACITY = sat_pkg::DEF_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sat_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [sat_pkg::VALUE_W-1:0] key_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [sat_pkg::POS_W-1:0]          position_o,
  output logic signed [sat_pkg::VALUE_W-1:0] entry_value_o,
  output logic [sat_pkg::FILL_W-1:0]         fill_count_o,
  output logic                               last_o
);
  import sat_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  result_t            emit;
  logic               out_free;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic [VALUE_W-1:0] entry_value;

  // Request sequencer.
  sat_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .key_value_i(key_value_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Entry store.
  sat_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Result register.
  sat_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .entry_value_o(entry_value),
    .fill_count_o (fill_count_o),
    .last_o       (last_o)
  );

  assign entry_value_o = $signed(entry_value);

endmodule

// ----- design/sat_checker.sv -----
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sat_checker #(
  parameter int CAPACITY = sat_pkg::DEF_CAPACITY
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [1:0]                         status_o,
  input logic [sat_pkg::POS_W-1:0]          position_o,
  input logic signed [sat_pkg::VALUE_W-1:0] entry_value_o,
  input logic [sat_pkg::FILL_W-1:0]         fill_count_o,
  input logic                               last_o
);
  import sat_pkg::*;

  logic                            res_held;
  logic                            res_err;
  logic                            res_full;
  logic [POS_W+VALUE_W+FILL_W+2:0] res_word;

  // Result terms shared by the checks below.
  assign res_held = out_valid_o && !out_ready_i;
  assign res_err  = out_valid_o && (status_o != ST_OK);
  assign res_full = out_valid_o && (status_o == ST_FULL);
  assign res_word = {status_o, position_o, entry_value_o, fill_count_o, last_o};

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, res_held, out_valid_o && $stable(res_word), "result changed")

  // The reported count never exceeds the table size.
  `ASSERT_IMP(a_fill_range, clk_i, rst_ni, out_valid_o, fill_count_o <= CAPACITY, "count too large")

  // A refused insert is only reported on a full table.
  `ASSERT_IMP(a_full_count, clk_i, rst_ni, res_full, fill_count_o == CAPACITY, "full with room")

  // Error results are single and carry position zero.
  `ASSERT_IMP(a_err_single, clk_i, rst_ni, res_err, last_o && position_o == '0, "bad error result")

  // While a dump is in progress no new request is taken.
  `ASSERT_IMP(a_dump_busy, clk_i, rst_ni, out_valid_o && !last_o, !in_ready_o, "request during dump")

endmodule

bind sorted_array_table_core sat_checker #(.CAPACITY(CAPACITY)) u_sat_checker (.*);

// ----- verif/sorted_array_table_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_array_table_checker
// Watches the request and result channels of the sorted table. It keeps its
// own copy of the table, works out the results of every accepted request and
// compares each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sorted_array_table_checker
  import sat_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [REQ_W-1:0]          req_type_i,
  input  logic signed [VALUE_W-1:0] key_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [1:0]                status_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic signed [VALUE_W-1:0] entry_value_i,
  input  logic [FILL_W-1:0]         fill_count_i,
  input  logic                      last_i,
  output int                        mismatch_count_o,
  output int                        pending_results_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // One result as the table should produce it.
  typedef struct {
    status_e                   status;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic [FILL_W-1:0]         fill;
    logic                      last;
  } table_result_t;

  // Shadow copy of the table contents and the results still owed.
  logic signed [VALUE_W-1:0] stored_values [CAPACITY];
  int                        stored_count;
  table_result_t             expected_results [$];

  initial begin
    mismatch_count_o  = 0;
    pending_results_o = 0;
    stored_count      = 0;
  end

  function automatic void push_result(status_e st, int pos, logic signed [VALUE_W-1:0] val,
                                      int fill, logic last_flag);
    table_result_t res;
    res.status   = st;
    res.position = POS_W'(pos);
    res.value    = val;
    res.fill     = FILL_W'(fill);
    res.last     = last_flag;
    expected_results.push_back(res);
  endfunction

  // Applies one request to the shadow table and queues the results it causes.
  function automatic void predict_table_request(req_e req, logic signed [VALUE_W-1:0] key);
    int slot;
    int hit;
    if (req == REQ_INSERT) begin
      if (stored_count >= CAPACITY) begin
        push_result(ST_FULL, 0, key, stored_count, 1'b1);
      end else begin
        // Larger and equal entries move up, so the new value lands before its equals.
        slot = stored_count;
        while (slot > 0 && stored_values[slot-1] >= key) begin
          stored_values[slot] = stored_values[slot-1];
          slot--;
        end
        stored_values[slot] = key;
        stored_count++;
        push_result(ST_OK, slot, key, stored_count, 1'b1);
      end
    end else if (stored_count == 0) begin
      push_result(ST_EMPTY, 0, key, 0, 1'b1);
    end else if (req == REQ_DUMP) begin
      for (int i = 0; i < stored_count; i++) begin
        push_result(ST_OK, i, stored_values[i], stored_count, i + 1 == stored_count);
      end
    end else begin
      // Search and delete both work on the lowest index holding the key.
      hit = -1;
      for (int i = 0; i < stored_count; i++) begin
        if (hit < 0 && stored_values[i] == key) hit = i;
      end
      if (hit < 0) begin
        push_result(ST_MISSING, 0, key, stored_count, 1'b1);
      end else if (req == REQ_SEARCH) begin
        push_result(ST_OK, hit, stored_values[hit], stored_count, 1'b1);
      end else begin
        for (int i = hit; i + 1 < stored_count; i++) stored_values[i] = stored_values[i+1];
        stored_count--;
        push_result(ST_OK, hit, key, stored_count, 1'b1);
      end
    end
  endfunction

  // Compares one accepted result with the oldest outstanding expectation.
  function automatic void check_result();
    table_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10) begin
        $display("%0t: result with no request outstanding: status %0d position %0d",
                 $realtime, status_i, position_i);
        $display("    value %0d fill %0d last %0d", entry_value_i, fill_count_i, last_i);
      end
    end else begin
      want = expected_results.pop_front();
      if (status_i != want.status || position_i != want.position ||
          entry_value_i != want.value || fill_count_i != want.fill || last_i != want.last) begin
        mismatch_count_o++;
        if (mismatch_count_o <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("    expected status %0d position %0d value %0d fill %0d last %0d",
                   want.status, want.position, want.value, want.fill, want.last);
          $display("    actual   status %0d position %0d value %0d fill %0d last %0d",
                   status_i, position_i, entry_value_i, fill_count_i, last_i);
        end
      end
    end
  endfunction

  // Results are checked before new requests are predicted: a result leaving
  // at the same edge always belongs to an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_table_request(req_e'(req_type_i), key_value_i);
    end
    pending_results_o = expected_results.size();
  end

endmodule

// ----- verif/sorted_array_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_array_table_core_tb
// Drives directed and random insert, delete, search and dump requests into
// the sorted table with random gaps on both channels and one long output
// stall, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module sorted_array_table_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int  CAPACITY       = DEF_CAPACITY;
  localparam real CLK_PERIOD     = 4.0;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  HOLD_AFTER     = 50;
  localparam int  WATCHDOG_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] MIN_KEY = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MAX_KEY = 32'sh7FFF_FFFF;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [REQ_W-1:0]          req_type_i;
  logic signed [VALUE_W-1:0] key_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                status_o;
  logic [POS_W-1:0]          position_o;
  logic signed [VALUE_W-1:0] entry_value_o;
  logic [FILL_W-1:0]         fill_count_o;
  logic                      last_o;

  int                        mismatch_count;
  int                        pending_results;
  int                        accepted_requests = 0;
  int                        stall_cycles      = 0;
  bit                        calm_phase        = 1'b0;
  bit                        hold_done         = 1'b0;
  logic signed [VALUE_W-1:0] key_pool [8];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sorted_array_table_core #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_value_o (entry_value_o),
    .fill_count_o  (fill_count_o),
    .last_o        (last_o)
  );

  sorted_array_table_checker #(
    .CAPACITY (CAPACITY)
  ) checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .req_type_i        (req_type_i),
    .key_value_i       (key_value_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .position_i        (position_o),
    .entry_value_i     (entry_value_o),
    .fill_count_i      (fill_count_o),
    .last_i            (last_o),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  // Offers one request, sometimes after a short gap, and waits for acceptance.
  task automatic send_request(input req_e req, input logic signed [VALUE_W-1:0] key);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    key_value_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    accepted_requests++;
  endtask

  // Picks a request type from percentage weights; the remainder is dump.
  function automatic req_e pick_request(int ins_w, int del_w, int srch_w);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) return REQ_INSERT;
    if (roll < ins_w + del_w) return REQ_DELETE;
    if (roll < ins_w + del_w + srch_w) return REQ_SEARCH;
    return REQ_DUMP;
  endfunction

  // Keys come mostly from a small pool so that duplicates and hits are common.
  function automatic logic signed [VALUE_W-1:0] pick_key();
    case ($urandom_range(0, 19))
      0, 1:    return $urandom;
      2:       return MIN_KEY;
      3:       return MAX_KEY;
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // A run of random requests; idling stops from item calm_from onwards.
  task automatic random_phase(int count, int ins_w, int del_w, int srch_w, int calm_from);
    for (int i = 0; i < count; i++) begin
      if (i == calm_from) calm_phase = 1'b1;
      send_request(pick_request(ins_w, del_w, srch_w), pick_key());
    end
  endtask

  // Result side: random stall bursts, one long hold-off, none near the end.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && accepted_requests >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
  end

  // Counts cycles in which neither channel moves a request or a result.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni);
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("** sorted_array_table_core: FAILED **");
    $finish;
  end

  // Request side: reset, directed requests, random phases and the verdict.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_INSERT;
    key_value_i = '0;
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = (i < 6) ? int'($urandom_range(0, 40)) - 20 : int'($urandom);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Dump, search and delete on an empty table.
    send_request(REQ_DUMP,   32'shA5A5_5A5A);
    send_request(REQ_SEARCH, -1);
    send_request(REQ_DELETE, -1);

    // Inserts at the extremes, with a duplicate that must land before its equal.
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, MAX_KEY);
    send_request(REQ_INSERT, MIN_KEY);
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, 5);

    // Hits at both ends and on the duplicate, then a miss.
    send_request(REQ_SEARCH, 0);
    send_request(REQ_SEARCH, MAX_KEY);
    send_request(REQ_SEARCH, MIN_KEY);
    send_request(REQ_SEARCH, 1234);
    send_request(REQ_DUMP,   0);

    // Deletes from the middle, the bottom and the top, and a miss.
    send_request(REQ_DELETE, 0);
    send_request(REQ_DELETE, MIN_KEY);
    send_request(REQ_DELETE, MAX_KEY);
    send_request(REQ_DELETE, 77);
    send_request(REQ_DUMP,   MIN_KEY);

    // Drain to empty and dump the empty table once more.
    send_request(REQ_DELETE, 0);
    send_request(REQ_DELETE, -1);
    send_request(REQ_DELETE, 5);
    send_request(REQ_DUMP,   MAX_KEY);

    // Insert-heavy phase fills the table and hits the full case.
    random_phase(40, 70, 10, 10, -1);
    // Mixed traffic around the full mark.
    random_phase(20, 35, 30, 25, -1);
    // Delete-heavy phase drains the table; the tail runs without idling.
    random_phase(18, 10, 65, 15, 8);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results == 0);
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("** sorted_array_table_core: PASSED **");
    end else begin
      $display("** sorted_array_table_core: FAILED **");
    end
    $finish;
  end

endmodule
